// ----- rtl/rti_pkg.sv -----
`default_nettype none

package rti_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_DIR_X       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_Z       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DET_EPSILON = 2'd3;

    localparam int EPS_WIDTH = 32;
    localparam int EPS_FRAC  = 24;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd17;
    localparam int DIR_Y_RESET = 256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

`default_nettype wire

// ----- rtl/rti_front.sv -----
`default_nettype none

module rti_front #(
    parameter int COORD_WIDTH = 16,
    parameter int IN_DATA_W   = 192,
    parameter int EDGE_DATA_W = 153
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [IN_DATA_W-1:0]   i_data,
    input  wire rti_pkg::t_queue_status i_q_status,
    output logic                        o_push,
    output logic [EDGE_DATA_W-1:0]      o_push_data
);

    localparam int W = COORD_WIDTH;
    localparam int H = COORD_WIDTH + 1;

    logic                   r_vld;
    logic [EDGE_DATA_W-1:0] r_data;
    logic [EDGE_DATA_W-1:0] n_data;
    logic                   w_push;
    logic                   w_load;

    logic signed [W-1:0] w_org [3];
    logic signed [W-1:0] w_a   [3];
    logic signed [W-1:0] w_b   [3];
    logic signed [W-1:0] w_c   [3];
    logic signed [H-1:0] w_e1  [3];
    logic signed [H-1:0] w_e2  [3];
    logic signed [H-1:0] w_tv  [3];

    assign w_push  = r_vld && !i_q_status.full;
    assign o_ready = !r_vld || w_push;
    assign w_load  = i_valid && o_ready;

    // edge1, edge2 and tvec, each axis in its own slot
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_org[i] = i_data[i*W +: W];
            w_a[i]   = i_data[(3+i)*W +: W];
            w_b[i]   = i_data[(6+i)*W +: W];
            w_c[i]   = i_data[(9+i)*W +: W];
            w_e1[i]  = H'(w_b[i]) - H'(w_a[i]);
            w_e2[i]  = H'(w_c[i]) - H'(w_a[i]);
            w_tv[i]  = H'(w_org[i]) - H'(w_a[i]);
        end
        n_data = '0;
        for (int i = 0; i < 3; i++) begin
            n_data[i*H +: H]     = w_e1[i];
            n_data[(3+i)*H +: H] = w_e2[i];
            n_data[(6+i)*H +: H] = w_tv[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (w_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_push      = w_push;
    assign o_push_data = r_data;

endmodule

`default_nettype wire

// ----- rtl/rti_queue.sv -----
`default_nettype none

module rti_queue #(
    parameter int DATA_W = 153
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [DATA_W-1:0]  i_push_data,
    input  wire logic               i_pop,
    output logic [DATA_W-1:0]       o_pop_data,
    output rti_pkg::t_queue_status  o_status
);

    localparam int PW = rti_pkg::QUEUE_PTR_W;

    logic [DATA_W-1:0] r_mem [rti_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (PW+1)'(rti_pkg::QUEUE_DEPTH));
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_pop_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rti_back.sv -----
`default_nettype none

module rti_back #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8,
    parameter int EDGE_DATA_W = 153
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [3*COORD_WIDTH-1:0]          i_dir,
    input  wire logic [rti_pkg::EPS_WIDTH-1:0]     i_eps,
    input  wire rti_pkg::t_queue_status            i_q_status,
    input  wire logic [EDGE_DATA_W-1:0]            i_q_data,
    output logic                                   o_pop,
    output logic                                   o_m_valid,
    input  wire logic                              i_m_ready,
    output logic [rti_pkg::OUT_DATA_W-1:0]         o_m_data
);

    localparam int W    = COORD_WIDTH;
    localparam int H    = COORD_WIDTH + 1;
    localparam int PW   = 2 * H;
    localparam int QW   = 2 * H + 1;
    localparam int SW   = 3 * H + 3;
    localparam int CW_A = rti_pkg::EPS_WIDTH + 3 * FRAC_BITS;
    localparam int CW_B = SW + rti_pkg::EPS_FRAC;
    localparam int CW   = ((CW_A > CW_B) ? CW_A : CW_B) + 1;

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_hit;

    logic signed [W-1:0] w_dir [3];
    logic signed [H-1:0] w_e1  [3];
    logic signed [H-1:0] w_e2  [3];
    logic signed [H-1:0] w_tv  [3];

    logic signed [PW-1:0] r_pp  [6];
    logic signed [PW-1:0] r_qp  [6];
    logic signed [H-1:0]  r1_e1 [3];
    logic signed [H-1:0]  r1_tv [3];

    logic signed [PW-1:0] r_pv  [3];
    logic signed [QW-1:0] r_qv  [3];
    logic signed [H-1:0]  r2_e1 [3];
    logic signed [H-1:0]  r2_tv [3];

    logic signed [QW-1:0] r_dh [3];
    logic signed [QW-1:0] r_dl [3];
    logic signed [QW-1:0] r_uh [3];
    logic signed [QW-1:0] r_ul [3];
    logic signed [QW-1:0] r_vh [3];
    logic signed [QW-1:0] r_vl [3];

    logic signed [SW-1:0] r_det;
    logic signed [SW-1:0] r_u;
    logic signed [SW-1:0] r_v;
    logic signed [SW-1:0] n_det;
    logic signed [SW-1:0] n_u;
    logic signed [SW-1:0] n_v;

    logic signed [SW-1:0] w_uv;
    logic        [SW-1:0] w_adet;
    logic        [CW-1:0] w_eps_al;
    logic        [CW-1:0] w_adet_al;
    logic                 w_near;
    logic                 w_in_pos;
    logic                 w_in_neg;
    logic                 n_hit;

    // all stages move together; the output stage frees when taken
    assign w_en      = !r_v5 || i_m_ready;
    assign o_pop     = w_en && !i_q_status.empty;
    assign o_m_valid = r_v5;
    assign o_m_data  = {{(rti_pkg::OUT_DATA_W-1){1'b0}}, r_hit};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dir[i] = i_dir[i*W +: W];
            w_e1[i]  = i_q_data[i*H +: H];
            w_e2[i]  = i_q_data[(3+i)*H +: H];
            w_tv[i]  = i_q_data[(6+i)*H +: H];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_q_status.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1 and 2: cross products pvec = dir x e2, qvec = tvec x e1
    for (genvar gi = 0; gi < 3; gi++) begin : g_cross
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pp[2*gi]   <= w_dir[J] * w_e2[K];
                r_pp[2*gi+1] <= w_dir[K] * w_e2[J];
                r_qp[2*gi]   <= w_tv[J] * w_e1[K];
                r_qp[2*gi+1] <= w_tv[K] * w_e1[J];
                r1_e1[gi]    <= w_e1[gi];
                r1_tv[gi]    <= w_tv[gi];
                r_pv[gi]     <= r_pp[2*gi] - r_pp[2*gi+1];
                r_qv[gi]     <= r_qp[2*gi] - r_qp[2*gi+1];
                r2_e1[gi]    <= r1_e1[gi];
                r2_tv[gi]    <= r1_tv[gi];
            end
        end
    end

    // stage 3: dot product terms, wide operand split in high and low halves
    for (genvar gi = 0; gi < 3; gi++) begin : g_part
        logic signed [H-1:0] w_pv_hi;
        logic signed [H:0]   w_pv_lo;
        logic signed [H:0]   w_qv_hi;
        logic signed [H:0]   w_qv_lo;

        assign w_pv_hi = r_pv[gi][PW-1:H];
        assign w_pv_lo = {1'b0, r_pv[gi][H-1:0]};
        assign w_qv_hi = r_qv[gi][QW-1:H];
        assign w_qv_lo = {1'b0, r_qv[gi][H-1:0]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dh[gi] <= r2_e1[gi] * w_pv_hi;
                r_dl[gi] <= r2_e1[gi] * w_pv_lo;
                r_uh[gi] <= r2_tv[gi] * w_pv_hi;
                r_ul[gi] <= r2_tv[gi] * w_pv_lo;
                r_vh[gi] <= w_dir[gi] * w_qv_hi;
                r_vl[gi] <= w_dir[gi] * w_qv_lo;
            end
        end
    end

    // stage 4: det, u and v unscaled
    always_comb begin
        n_det = '0;
        n_u   = '0;
        n_v   = '0;
        for (int i = 0; i < 3; i++) begin
            n_det = n_det + (SW'(r_dh[i]) <<< H) + SW'(r_dl[i]);
            n_u   = n_u   + (SW'(r_uh[i]) <<< H) + SW'(r_ul[i]);
            n_v   = n_v   + (SW'(r_vh[i]) <<< H) + SW'(r_vl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det <= n_det;
            r_u   <= n_u;
            r_v   <= n_v;
        end
    end

    // stage 5: parallel threshold and barycentric bounds
    always_comb begin
        w_uv      = r_u + r_v;
        w_adet    = r_det[SW-1] ? SW'(-r_det) : SW'(r_det);
        w_eps_al  = CW'(i_eps) << (3 * FRAC_BITS);
        w_adet_al = CW'(w_adet) << rti_pkg::EPS_FRAC;
        w_near    = (r_det == '0) || (w_adet_al < w_eps_al);
        w_in_pos  = (r_u >= 0) && (r_u <= r_det) && (r_v >= 0) && (w_uv <= r_det);
        w_in_neg  = (r_u <= 0) && (r_det <= r_u) && (r_v <= 0) && (r_det <= w_uv);
        n_hit     = !w_near && (r_det[SW-1] ? w_in_neg : w_in_pos);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= n_hit;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ray_triangle_intersect_top.sv -----
`default_nettype none

// channel   direction  handshake                         payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready i_s_axis_tdata
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready o_m_axis_tdata
// cfg       in         i_cfg_we                          i_cfg_addr, i_cfg_data
//
// one transaction per cycle in, one result per cycle out, while m_axis takes each result
// data path: front register, queue entry, five back stages
// the back pipeline holds when its output is not taken; the 4-entry queue
// then fills and the front stalls s_axis
// synchronous active-low reset empties all stages and the queue, restores registers

module ray_triangle_intersect_top #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // origin_x, origin_y, origin_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // hit
    output logic [rti_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [rti_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [rti_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int W           = COORD_WIDTH;
    localparam int IN_DATA_W   = ((12 * COORD_WIDTH + 7) / 8) * 8;
    localparam int EDGE_DATA_W = 9 * (COORD_WIDTH + 1);

    logic [W-1:0]                   r_dir_x;
    logic [W-1:0]                   r_dir_y;
    logic [W-1:0]                   r_dir_z;
    logic [rti_pkg::EPS_WIDTH-1:0]  r_eps;

    rti_pkg::t_queue_status  w_q_status;
    logic                    w_push;
    logic [EDGE_DATA_W-1:0]  w_push_data;
    logic                    w_pop;
    logic [EDGE_DATA_W-1:0]  w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= '0;
            r_dir_y <= W'(rti_pkg::DIR_Y_RESET);
            r_dir_z <= '0;
            r_eps   <= rti_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rti_pkg::REG_DIR_X:       r_dir_x <= i_cfg_data[W-1:0];
                rti_pkg::REG_DIR_Y:       r_dir_y <= i_cfg_data[W-1:0];
                rti_pkg::REG_DIR_Z:       r_dir_z <= i_cfg_data[W-1:0];
                rti_pkg::REG_DET_EPSILON: r_eps   <= i_cfg_data[rti_pkg::EPS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    rti_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .IN_DATA_W   (IN_DATA_W),
        .EDGE_DATA_W (EDGE_DATA_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    rti_queue #(
        .DATA_W (EDGE_DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    rti_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .EDGE_DATA_W (EDGE_DATA_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      ({r_dir_z, r_dir_y, r_dir_x}),
        .i_eps      (r_eps),
        .i_q_status (w_q_status),
        .i_q_data   (w_pop_data),
        .o_pop      (w_pop),
        .o_m_valid  (o_m_axis_tvalid),
        .i_m_ready  (i_m_axis_tready),
        .o_m_data   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
